// ===== rtl/ect_pkg.sv =====
// ----------------------------------------------------------------------------
// ect_pkg
// Shared constants of the ear-clipping triangulator: default sizes and the
// depth of the queues between its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package ect_pkg;

	localparam int COORD_WIDTH_DEF  = 16;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int FIFO_DEPTH       = 2;

endpackage

`default_nettype wire

// ===== rtl/ect_fifo.sv =====
// ----------------------------------------------------------------------------
// ect_fifo
// Small register queue with full and empty flags, used for the job queue
// and for the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ect_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ect_pkg::FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (PTR_W+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PTR_W+1)'(DEPTH))
		else $error("queue count beyond depth");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not follow a lone write");
`endif

endmodule

`default_nettype wire

// ===== rtl/ect_turn.sv =====
// ----------------------------------------------------------------------------
// ect_turn
// Three-stage orientation unit: sign of (u-o) x (v-o), with registered
// differences, products and comparison as its stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ect_turn #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic signed [COORD_WIDTH-1:0] o_x,
	input  logic signed [COORD_WIDTH-1:0] o_y,
	input  logic signed [COORD_WIDTH-1:0] u_x,
	input  logic signed [COORD_WIDTH-1:0] u_y,
	input  logic signed [COORD_WIDTH-1:0] v_x,
	input  logic signed [COORD_WIDTH-1:0] v_y,
	output logic                          neg,
	output logic                          pos
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] dux_s1, duy_s1, dvx_s1, dvy_s1;
	logic signed [PW-1:0] m1_s2, m2_s2;
	logic signed [PW:0]   diff;
	logic                 neg_s3, pos_s3;

	assign diff = (PW+1)'(m1_s2) - (PW+1)'(m2_s2);

	always_ff @(posedge clk) begin
		dux_s1 <= DW'(u_x) - DW'(o_x);
		duy_s1 <= DW'(u_y) - DW'(o_y);
		dvx_s1 <= DW'(v_x) - DW'(o_x);
		dvy_s1 <= DW'(v_y) - DW'(o_y);
		m1_s2  <= dux_s1 * dvy_s1;
		m2_s2  <= duy_s1 * dvx_s1;
		neg_s3 <= diff < 0;
		pos_s3 <= diff > 0;
	end

	assign neg = neg_s3;
	assign pos = pos_s3;

endmodule

`default_nettype wire

// ===== rtl/ect_front.sv =====
// ----------------------------------------------------------------------------
// ect_front
// Vertex loader: stores up to MAX_VERTICES vertices, accumulates the shoelace
// area and hands one job per polygon to the clipper.
// ----------------------------------------------------------------------------
`default_nettype none

module ect_front #(
	parameter int COORD_WIDTH  = 16,
	parameter int MAX_VERTICES = 64,
	localparam int IDX_W       = $clog2(MAX_VERTICES),
	localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic                          last_vertex,
	output logic                          full,
	output logic                          wr_en,
	output logic [IDX_W-1:0]              wr_addr,
	output logic [2*COORD_WIDTH-1:0]      wr_data,
	output logic                          job_push,
	output logic [CNT_W:0]                job_data,
	input  logic                          job_full,
	input  logic                          done
);

	localparam int PW     = 2 * COORD_WIDTH;
	localparam int AREA_W = PW + 2 + CNT_W;

	typedef enum logic [4:0] {
		F_LOAD  = 5'b00001,
		F_CLOSE = 5'b00010,
		F_DRAIN = 5'b00100,
		F_PUSH  = 5'b01000,
		F_WAIT  = 5'b10000
	} fstate_t;

	fstate_t                       state_q;
	logic [CNT_W-1:0]              cnt_q;
	logic signed [AREA_W-1:0]      acc_q;
	logic                          prod_v_s1;
	logic signed [PW-1:0]          p1_s1, p2_s1;
	logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic signed [COORD_WIDTH-1:0] op_x, op_y;
	logic                          accept, store, close;

	assign full   = (state_q != F_LOAD);
	assign accept = push && !full;
	assign store  = accept && (cnt_q < CNT_W'(MAX_VERTICES));
	assign close  = (state_q == F_CLOSE);

	// The closing edge runs from the last stored vertex back to the first.
	assign op_x = close ? first_x_q : vertex_x;
	assign op_y = close ? first_y_q : vertex_y;

	assign wr_en    = store;
	assign wr_addr  = cnt_q[IDX_W-1:0];
	assign wr_data  = {vertex_x, vertex_y};
	assign job_push = (state_q == F_PUSH) && !job_full;
	assign job_data = {acc_q[AREA_W-1], cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_LOAD;
			cnt_q     <= '0;
			acc_q     <= '0;
			prod_v_s1 <= 1'b0;
		end else begin
			prod_v_s1 <= (store && (cnt_q != '0)) || close;
			if (prod_v_s1) begin
				acc_q <= acc_q + AREA_W'(p1_s1) - AREA_W'(p2_s1);
			end
			if (store) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				F_LOAD: begin
					if (accept && last_vertex) begin
						state_q <= F_CLOSE;
					end
				end
				F_CLOSE: state_q <= F_DRAIN;
				F_DRAIN: state_q <= F_PUSH;
				F_PUSH: begin
					if (!job_full) begin
						state_q <= F_WAIT;
					end
				end
				F_WAIT: begin
					if (done) begin
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= F_LOAD;
					end
				end
				default: state_q <= F_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p1_s1 <= prev_x_q * op_y;
		p2_s1 <= op_x * prev_y_q;
		if (store) begin
			prev_x_q <= vertex_x;
			prev_y_q <= vertex_y;
			if (cnt_q == '0) begin
				first_x_q <= vertex_x;
				first_y_q <= vertex_y;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ect_clip.sv =====
// ----------------------------------------------------------------------------
// ect_clip
// Clipping sequencer: holds the vertex and order memories, tests candidate
// ears with a shared orientation unit and writes triangles to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ect_clip #(
	parameter int COORD_WIDTH  = 16,
	parameter int MAX_VERTICES = 64,
	localparam int IDX_W       = $clog2(MAX_VERTICES),
	localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_addr,
	input  logic [2*COORD_WIDTH-1:0]   wr_data,
	input  logic                       job_empty,
	input  logic [CNT_W:0]             job_data,
	output logic                       job_pop,
	input  logic                       res_full,
	output logic                       res_push,
	output logic [6*COORD_WIDTH+2:0]   res_data,
	output logic                       done
);

	localparam int W = COORD_WIDTH;

	typedef enum logic [11:0] {
		B_IDLE  = 12'b0000_0000_0001,
		B_EMPTY = 12'b0000_0000_0010,
		B_INIT  = 12'b0000_0000_0100,
		B_TOP   = 12'b0000_0000_1000,
		B_FAN   = 12'b0000_0001_0000,
		B_FETCH = 12'b0000_0010_0000,
		B_EAR   = 12'b0000_0100_0000,
		B_SCAN  = 12'b0000_1000_0000,
		B_EMIT  = 12'b0001_0000_0000,
		B_SHIFT = 12'b0010_0000_0000,
		B_MISS  = 12'b0100_0000_0000,
		B_DONE  = 12'b1000_0000_0000
	} bstate_t;

	logic [2*W-1:0]   coord_mem [MAX_VERTICES];
	logic [IDX_W-1:0] link_mem  [MAX_VERTICES];
	logic [2*W-1:0]   crd_q;
	logic [IDX_W-1:0] lrd_q;
	logic [IDX_W-1:0] lrd_addr, lwr_addr, lwr_data;
	logic             lwr_en;

	bstate_t          state_q;
	logic [CNT_W-1:0] n_q, i_q;
	logic [IDX_W-1:0] cp_q;
	logic [CNT_W:0]   failed_q;
	logic [3:0]       sub_q;
	logic             rev_q, fan_q;

	logic [IDX_W-1:0]     pos0_q, pos1_q, pos2_q, ia_q, ib_q, ic_q;
	logic signed [W-1:0]  ax_q, ay_q, bx_q, by_q, cx_q, cy_q, px_q, py_q;
	logic                 neg_acc_q, pos_acc_q;

	logic [CNT_W-1:0]    n_m1, i_inc, cp_ext, cp_inc, rev_idx;
	logic [CNT_W:0]      i_p2, failed_inc;
	logic [IDX_W-1:0]    pa, pc;
	logic signed [W-1:0] crd_x, crd_y;
	logic                fan_last, hit_idx, hit_pos, neg_all, pos_all;
	logic                next_j, veto;
	logic signed [W-1:0] t_ox, t_oy, t_ux, t_uy, t_vx, t_vy;
	logic                t_neg, t_pos;

	// The coordinate memory is always read at the order memory's output.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			coord_mem[wr_addr] <= wr_data;
		end
		crd_q <= coord_mem[lrd_q];
	end

	always_ff @(posedge clk) begin
		if (lwr_en) begin
			link_mem[lwr_addr] <= lwr_data;
		end
		lrd_q <= link_mem[lrd_addr];
	end

	assign n_m1       = n_q - 1'b1;
	assign i_inc      = i_q + 1'b1;
	assign i_p2       = (CNT_W+1)'(i_q) + (CNT_W+1)'(2);
	assign cp_ext     = CNT_W'(cp_q);
	assign cp_inc     = cp_ext + 1'b1;
	assign rev_idx    = n_m1 - i_q;
	assign failed_inc = failed_q + 1'b1;
	assign pa         = (cp_q == '0) ? n_m1[IDX_W-1:0] : cp_q - 1'b1;
	assign pc         = (cp_inc == n_q) ? '0 : cp_inc[IDX_W-1:0];
	assign fan_last   = fan_q && (i_p2 == {1'b0, n_q});
	assign crd_x      = crd_q[2*W-1:W];
	assign crd_y      = crd_q[W-1:0];
	assign hit_idx    = (lrd_q == ia_q) || (lrd_q == ib_q) || (lrd_q == ic_q);
	assign hit_pos    = ((crd_x == ax_q) && (crd_y == ay_q))
	                 || ((crd_x == bx_q) && (crd_y == by_q))
	                 || ((crd_x == cx_q) && (crd_y == cy_q));
	assign neg_all    = neg_acc_q || t_neg;
	assign pos_all    = pos_acc_q || t_pos;

	// A point that sees the triangle's edges turning both ways lies outside it.
	assign veto   = (state_q == B_SCAN) && (sub_q == 4'd8) && !(neg_all && pos_all);
	assign next_j = ((sub_q == 4'd1) && hit_idx) || ((sub_q == 4'd2) && hit_pos)
	             || ((sub_q == 4'd8) && neg_all && pos_all);

	always_comb begin
		t_ox = ax_q; t_oy = ay_q;
		t_ux = bx_q; t_uy = by_q;
		t_vx = cx_q; t_vy = cy_q;
		if (state_q == B_SCAN) begin
			unique case (sub_q)
				4'd4: begin
					t_ox = bx_q; t_oy = by_q;
					t_ux = cx_q; t_uy = cy_q;
					t_vx = px_q; t_vy = py_q;
				end
				4'd5: begin
					t_ox = cx_q; t_oy = cy_q;
					t_ux = ax_q; t_uy = ay_q;
					t_vx = px_q; t_vy = py_q;
				end
				default: begin
					t_vx = px_q; t_vy = py_q;
				end
			endcase
		end
	end

	ect_turn #(.COORD_WIDTH(COORD_WIDTH)) u_turn (
		.clk (clk),
		.o_x (t_ox),
		.o_y (t_oy),
		.u_x (t_ux),
		.u_y (t_uy),
		.v_x (t_vx),
		.v_y (t_vy),
		.neg (t_neg),
		.pos (t_pos)
	);

	always_comb begin
		unique case (state_q)
			B_FETCH: begin
				unique case (sub_q)
					4'd1: lrd_addr = pos1_q;
					4'd2: lrd_addr = pos2_q;
					default: lrd_addr = pos0_q;
				endcase
			end
			B_SCAN:  lrd_addr = i_q[IDX_W-1:0];
			B_SHIFT: lrd_addr = i_inc[IDX_W-1:0];
			default: lrd_addr = '0;
		endcase
	end

	assign lwr_en   = (state_q == B_INIT) || ((state_q == B_SHIFT) && (sub_q == 4'd1));
	assign lwr_addr = i_q[IDX_W-1:0];
	assign lwr_data = (state_q == B_INIT)
	                ? (rev_q ? rev_idx[IDX_W-1:0] : i_q[IDX_W-1:0]) : lrd_q;

	assign job_pop  = (state_q == B_IDLE) && !job_empty;
	assign done     = (state_q == B_DONE);
	assign res_push = ((state_q == B_EMIT) || (state_q == B_EMPTY)) && !res_full;
	assign res_data = (state_q == B_EMPTY)
	                ? {{(6*W){1'b0}}, 3'b011}
	                : {ax_q, ay_q, bx_q, by_q, cx_q, cy_q, fan_q, 1'b0, fan_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			n_q      <= '0;
			i_q      <= '0;
			cp_q     <= '0;
			failed_q <= '0;
			sub_q    <= '0;
			rev_q    <= 1'b0;
			fan_q    <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						if (job_data[CNT_W-1:0] < CNT_W'(3)) begin
							state_q <= B_EMPTY;
						end else begin
							n_q     <= job_data[CNT_W-1:0];
							rev_q   <= job_data[CNT_W];
							i_q     <= '0;
							state_q <= B_INIT;
						end
					end
				end
				B_EMPTY: begin
					if (!res_full) begin
						state_q <= B_DONE;
					end
				end
				B_INIT: begin
					if (i_inc == n_q) begin
						cp_q     <= '0;
						failed_q <= '0;
						state_q  <= B_TOP;
					end else begin
						i_q <= i_inc;
					end
				end
				B_TOP: begin
					if (n_q > CNT_W'(3)) begin
						fan_q   <= 1'b0;
						sub_q   <= '0;
						state_q <= B_FETCH;
					end else begin
						i_q     <= CNT_W'(1);
						state_q <= B_FAN;
					end
				end
				B_FAN: begin
					if (i_inc < n_q) begin
						fan_q   <= 1'b1;
						sub_q   <= '0;
						state_q <= B_FETCH;
					end else begin
						state_q <= B_DONE;
					end
				end
				B_FETCH: begin
					if (sub_q == 4'd4) begin
						sub_q   <= '0;
						state_q <= fan_q ? B_EMIT : B_EAR;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				B_EAR: begin
					if (sub_q == 4'd3) begin
						sub_q <= '0;
						if (t_pos) begin
							i_q     <= '0;
							state_q <= B_SCAN;
						end else begin
							state_q <= B_MISS;
						end
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				B_SCAN: begin
					if (veto) begin
						sub_q   <= '0;
						state_q <= B_MISS;
					end else if (next_j) begin
						sub_q <= '0;
						if (i_inc == n_q) begin
							state_q <= B_EMIT;
						end else begin
							i_q <= i_inc;
						end
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				B_EMIT: begin
					if (!res_full) begin
						if (fan_q) begin
							if (fan_last) begin
								state_q <= B_DONE;
							end else begin
								i_q     <= i_inc;
								state_q <= B_FAN;
							end
						end else begin
							i_q     <= cp_ext;
							sub_q   <= '0;
							state_q <= B_SHIFT;
						end
					end
				end
				B_SHIFT: begin
					// Close the gap left by the clipped tip: read each entry, then write it one place lower.
					if (sub_q == '0) begin
						if (i_inc >= n_q) begin
							n_q      <= n_m1;
							cp_q     <= (cp_ext == n_m1) ? '0 : cp_q;
							failed_q <= '0;
							state_q  <= B_TOP;
						end else begin
							sub_q <= 4'd1;
						end
					end else begin
						i_q   <= i_inc;
						sub_q <= '0;
					end
				end
				B_MISS: begin
					cp_q     <= pc;
					failed_q <= failed_inc;
					if (failed_inc > {1'b0, n_q}) begin
						i_q     <= CNT_W'(1);
						state_q <= B_FAN;
					end else begin
						state_q <= B_TOP;
					end
				end
				B_DONE: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_TOP) begin
			pos0_q <= pa;
			pos1_q <= cp_q;
			pos2_q <= pc;
		end
		if (state_q == B_FAN) begin
			pos0_q <= '0;
			pos1_q <= i_q[IDX_W-1:0];
			pos2_q <= i_inc[IDX_W-1:0];
		end
		if (state_q == B_FETCH) begin
			unique case (sub_q)
				4'd1: ia_q <= lrd_q;
				4'd2: begin
					ib_q <= lrd_q;
					ax_q <= crd_x;
					ay_q <= crd_y;
				end
				4'd3: begin
					ic_q <= lrd_q;
					bx_q <= crd_x;
					by_q <= crd_y;
				end
				4'd4: begin
					cx_q <= crd_x;
					cy_q <= crd_y;
				end
				default: ;
			endcase
		end
		if (state_q == B_SCAN) begin
			unique case (sub_q)
				4'd2: begin
					px_q <= crd_x;
					py_q <= crd_y;
				end
				4'd6: begin
					neg_acc_q <= t_neg;
					pos_acc_q <= t_pos;
				end
				4'd7: begin
					neg_acc_q <= neg_all;
					pos_acc_q <= pos_all;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("clipper state not one-hot");
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_TOP) |-> (cp_ext < n_q))
		else $error("cursor beyond remaining vertices");
	a_fan_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == B_EMIT) && fan_q) |-> (i_inc < n_q))
		else $error("fan corner beyond remaining vertices");
`endif

endmodule

`default_nettype wire

// ===== rtl/ear_clip_triangulate_core.sv =====
// ----------------------------------------------------------------------------
// ear_clip_triangulate_core
// Ear-clipping triangulator for one simple polygon at a time.
// ----------------------------------------------------------------------------
// Vertices are written with push while full is low, one word per cycle; the
// word with last_vertex set closes the polygon. Up to MAX_VERTICES vertices
// are kept, further ones are dropped but last_vertex still closes the polygon.
// Triangles are read with pop while empty is low; the final one of a polygon
// carries last_triangle. A polygon of fewer than three vertices gives one word
// with no_triangles set and zero corners.
// After the last vertex, full stays high until the polygon's final triangle
// has entered the two-word result queue: area and setup, then per candidate
// corner an ear test and, for a convex one, a containment scan over the
// remaining vertices, a gap closed after each ear, and the fan triangles. The
// shared orientation unit and the order memory's single read port pace these
// steps. A stalled reader holds the clipper only once the result queue is
// full. Reset empties both queues; the memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module ear_clip_triangulate_core #(
	parameter int COORD_WIDTH  = ect_pkg::COORD_WIDTH_DEF,
	parameter int MAX_VERTICES = ect_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic                          last_vertex,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_WIDTH-1:0] corner_a_x,
	output logic signed [COORD_WIDTH-1:0] corner_a_y,
	output logic signed [COORD_WIDTH-1:0] corner_b_x,
	output logic signed [COORD_WIDTH-1:0] corner_b_y,
	output logic signed [COORD_WIDTH-1:0] corner_c_x,
	output logic signed [COORD_WIDTH-1:0] corner_c_y,
	output logic                          from_fan,
	output logic                          no_triangles,
	output logic                          last_triangle
);

	import ect_pkg::*;

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int RES_W = 6 * COORD_WIDTH + 3;

	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic [2*COORD_WIDTH-1:0] wr_data;
	logic                     job_push, job_full, job_pop, job_empty;
	logic [CNT_W:0]           job_wdata, job_rdata;
	logic                     res_push, res_full;
	logic [RES_W-1:0]         res_wdata, res_rdata;
	logic                     done;

	ect_front #(
		.COORD_WIDTH  (COORD_WIDTH),
		.MAX_VERTICES (MAX_VERTICES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.full        (full),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.job_push    (job_push),
		.job_data    (job_wdata),
		.job_full    (job_full),
		.done        (done)
	);

	ect_fifo #(
		.WIDTH (CNT_W + 1),
		.DEPTH (FIFO_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_wdata),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.empty  (job_empty)
	);

	ect_clip #(
		.COORD_WIDTH  (COORD_WIDTH),
		.MAX_VERTICES (MAX_VERTICES)
	) u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.job_empty (job_empty),
		.job_data  (job_rdata),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_wdata),
		.done      (done)
	);

	ect_fifo #(
		.WIDTH (RES_W),
		.DEPTH (FIFO_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign {corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y,
	        from_fan, no_triangles, last_triangle} = res_rdata;

endmodule

`default_nettype wire

// ===== tb/ear_clip_triangulate_checker.sv =====
// ----------------------------------------------------------------------------
// ear_clip_triangulate_checker
// Watches both queues of the triangulator, predicts the triangles of every
// closed polygon and compares each word read from the block with them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module ear_clip_triangulate_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  wire               full,
	input  wire signed [15:0] vertex_x,
	input  wire signed [15:0] vertex_y,
	input  wire               last_vertex,
	input  wire               empty,
	input  wire               pop,
	input  wire signed [15:0] corner_a_x,
	input  wire signed [15:0] corner_a_y,
	input  wire signed [15:0] corner_b_x,
	input  wire signed [15:0] corner_b_y,
	input  wire signed [15:0] corner_c_x,
	input  wire signed [15:0] corner_c_y,
	input  wire               from_fan,
	input  wire               no_triangles,
	input  wire               last_triangle,
	output int                fail_count,
	output int                triangles_due
);

	localparam int MAX_VERTICES = ect_pkg::MAX_VERTICES_DEF;

	typedef struct packed {
		logic signed [15:0] ax, ay, bx, by, cx, cy;
		logic               fan, none, fin;
	} triangle_t;

	triangle_t    due_triangles[$];
	longint       poly_x[MAX_VERTICES];
	longint       poly_y[MAX_VERTICES];
	int           ring[MAX_VERTICES];
	int           loaded;

	function automatic longint turn(int a, int b, int c);
		return (poly_x[b] - poly_x[a]) * (poly_y[c] - poly_y[a])
		     - (poly_y[b] - poly_y[a]) * (poly_x[c] - poly_x[a]);
	endfunction

	function automatic bit same_spot(int p, int q);
		return poly_x[p] == poly_x[q] && poly_y[p] == poly_y[q];
	endfunction

	function automatic void emit(int a, int b, int c, bit fan, bit fin);
		triangle_t t;
		t.ax = 16'(poly_x[a]); t.ay = 16'(poly_y[a]);
		t.bx = 16'(poly_x[b]); t.by = 16'(poly_y[b]);
		t.cx = 16'(poly_x[c]); t.cy = 16'(poly_y[c]);
		t.fan = fan; t.none = 1'b0; t.fin = fin;
		due_triangles = {due_triangles, t};
	endfunction

	function automatic void clip_polygon();
		int     n, cur, fails, ia, ib, ic, p;
		longint area, d0, d1, d2;
		bit     ear;
		n = loaded;
		area = 0;
		for (int i = 0; i < n; i++) begin
			p = (i + 1 == n) ? 0 : i + 1;
			area += poly_x[i] * poly_y[p] - poly_x[p] * poly_y[i];
		end
		for (int i = 0; i < n; i++)
			ring[i] = (area < 0) ? n - 1 - i : i;
		cur = 0;
		fails = 0;
		while (n > 3) begin
			ia = ring[(cur + n - 1) % n];
			ib = ring[cur];
			ic = ring[(cur + 1) % n];
			ear = turn(ia, ib, ic) > 0;
			for (int j = 0; ear && j < n; j++) begin
				p = ring[j];
				if (p == ia || p == ib || p == ic)
					continue;
				if (same_spot(p, ia) || same_spot(p, ib) || same_spot(p, ic))
					continue;
				d0 = turn(ia, ib, p);
				d1 = turn(ib, ic, p);
				d2 = turn(ic, ia, p);
				if (!((d0 < 0 || d1 < 0 || d2 < 0) && (d0 > 0 || d1 > 0 || d2 > 0)))
					ear = 1'b0;
			end
			if (ear) begin
				emit(ia, ib, ic, 1'b0, 1'b0);
				for (int k = cur; k < n - 1; k++)
					ring[k] = ring[k + 1];
				n--;
				cur = cur % n;
				fails = 0;
			end else begin
				cur = (cur + 1) % n;
				fails++;
				if (fails > n)
					break;
			end
		end
		for (int i = 1; i + 1 < n; i++)
			emit(ring[0], ring[i], ring[i + 1], 1'b1, i + 2 == n);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		triangle_t got, want;
		if (!arst_n) begin
			loaded = 0;
			fail_count = 0;
			due_triangles.delete();
			triangles_due = 0;
		end else begin
			if (push && !full) begin
				if (loaded < MAX_VERTICES) begin
					poly_x[loaded] = vertex_x;
					poly_y[loaded] = vertex_y;
					loaded++;
				end
				if (last_vertex) begin
					if (loaded < 3) begin
						want = '0;
						want.none = 1'b1;
						want.fin = 1'b1;
						due_triangles = {due_triangles, want};
					end else begin
						clip_polygon();
					end
					loaded = 0;
				end
			end
			if (pop && !empty) begin
				got = {corner_a_x, corner_a_y, corner_b_x, corner_b_y,
				       corner_c_x, corner_c_y, from_fan, no_triangles, last_triangle};
				if (due_triangles.size() == 0) begin
					$display("%0t: mismatch expected nothing actual %h", $time, got);
					fail_count++;
				end else begin
					want = due_triangles.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %h actual %h", $time, want, got);
						fail_count++;
					end
				end
			end
			triangles_due = due_triangles.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/ear_clip_triangulate_core_test.sv =====
// ----------------------------------------------------------------------------
// ear_clip_triangulate_core_test
// Feeds directed and random polygons to the triangulator with bursty writes
// and a stalling reader; the checker beside the block predicts the triangles.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module ear_clip_triangulate_core_test;

	localparam int WATCHDOG_LIMIT = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic signed [15:0] vertex_x = '0;
	logic signed [15:0] vertex_y = '0;
	logic               last_vertex = 1'b0;
	logic               pop = 1'b0;
	wire                full, empty;
	wire signed [15:0]  corner_a_x, corner_a_y, corner_b_x, corner_b_y;
	wire signed [15:0]  corner_c_x, corner_c_y;
	wire                from_fan, no_triangles, last_triangle;
	int                 fail_count, triangles_due;
	int                 burst_left = 0;
	int                 vertices_sent = 0;
	bit                 hold_request = 1'b0;
	int                 quiet_cycles = 0;
	logic signed [15:0] shape_x[$], shape_y[$];

	always #5 clk = ~clk;

	ear_clip_triangulate_core u_top (.*);

	ear_clip_triangulate_checker u_checker (.*);

	// The reader stalls on its own pattern, with one long hold-off on request.
	initial begin
		int hold_left;
		int mode;
		bit hold_taken;
		hold_left = 0;
		mode = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_taken) begin
				hold_left = 3000;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0)
					mode = $urandom_range(0, 2);
				case (mode)
					0: pop <= 1'b1;
					1: pop <= $urandom_range(0, 3) != 0;
					default: pop <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
	                           input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		push <= 1'b1;
		vertex_x <= x;
		vertex_y <= y;
		last_vertex <= fin;
		do
			@(posedge clk);
		while (full);
		vertices_sent++;
		@(negedge clk);
	endtask

	task automatic send_shape(input bit flip);
		int n;
		n = shape_x.size();
		for (int i = 0; i < n; i++) begin
			if (flip)
				send_vertex(shape_x[n - 1 - i], shape_y[n - 1 - i], i == n - 1);
			else
				send_vertex(shape_x[i], shape_y[i], i == n - 1);
		end
		shape_x.delete();
		shape_y.delete();
	endtask

	task automatic add(input int x, input int y);
		shape_x = {shape_x, 16'(x)};
		shape_y = {shape_y, 16'(y)};
	endtask

	function automatic int coord(input int span);
		if (span == 0)
			return $signed(16'($urandom));
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// An x-monotone polygon: lower chain left to right, upper chain back.
	task automatic make_monotone(input int n, input int span);
		int xs[$], ys[$], tmp, lo_x[$], lo_y[$];
		longint side;
		for (int i = 0; i < n; i++) begin
			xs = {xs, coord(span)};
			ys = {ys, coord(span)};
		end
		for (int i = 1; i < n; i++)
			for (int j = i; j > 0 && xs[j - 1] > xs[j]; j--) begin
				tmp = xs[j]; xs[j] = xs[j - 1]; xs[j - 1] = tmp;
				tmp = ys[j]; ys[j] = ys[j - 1]; ys[j - 1] = tmp;
			end
		add(xs[0], ys[0]);
		for (int i = 1; i < n - 1; i++) begin
			side = longint'(xs[n - 1] - xs[0]) * (ys[i] - ys[0])
			     - longint'(ys[n - 1] - ys[0]) * (xs[i] - xs[0]);
			if (side < 0) begin
				add(xs[i], ys[i]);
			end else begin
				lo_x.push_front(xs[i]);
				lo_y.push_front(ys[i]);
			end
		end
		add(xs[n - 1], ys[n - 1]);
		foreach (lo_x[i])
			add(lo_x[i], lo_y[i]);
	endtask

	initial begin
		int n;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Too few vertices: one and two.
		add(-32768, 32767); send_shape(0);
		add(32767, -32768); add(0, 0); send_shape(0);
		// Triangles in both orientations.
		add(0, 0); add(100, 0); add(0, 100); send_shape(0);
		add(0, 0); add(100, 0); add(0, 100); send_shape(1);
		// Square over the whole coordinate range.
		add(-32768, -32768); add(32767, -32768); add(32767, 32767); add(-32768, 32767);
		send_shape(0);
		// Collinear points give zero area.
		add(0, 0); add(10, 10); add(20, 20); add(30, 30); send_shape(0);
		// Concave arrow, with a repeated corner.
		add(0, 0); add(40, 20); add(0, 40); add(10, 20); add(10, 20); send_shape(0);

		// More vertices than can be stored, read back under a long stall.
		hold_request = 1'b1;
		for (int i = 0; i < 66; i++)
			add(i * 400 - 13000, (i % 2) * 7000 + ((i * 37) % 500));
		send_shape(0);

		while (vertices_sent < 180) begin
			n = $urandom_range(0, 9);
			if (n == 0) begin
				repeat ($urandom_range(1, 6)) add(coord(0), coord(0));
				send_shape(0);
			end else if (n == 1) begin
				repeat ($urandom_range(1, 2)) add(coord(0), coord(0));
				send_shape(0);
			end else begin
				make_monotone($urandom_range(3, 12),
				              ($urandom_range(0, 2) == 0) ? 8 : 0);
				send_shape($urandom_range(0, 1) == 1);
			end
		end
		push <= 1'b0;
		last_vertex <= 1'b0;

		// The clipper may still be busy; the watchdog bounds this wait.
		while (triangles_due != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
